// ===== rtl/core/sliding_correlation_symbol_sync_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sliding correlation symbol sync
// Implication and next-cycle checks, removable with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef SLIDING_CORRELATION_SYMBOL_SYNC_MACROS_SVH
`define SLIDING_CORRELATION_SYMBOL_SYNC_MACROS_SVH
`ifndef ASSERT_OFF
`define SCSS_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("scss assertion failed");
`define SCSS_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("scss assertion failed");
`else
`define SCSS_ASSERT_IMP(label, clk, rstn, ante, cons)
`define SCSS_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/scss_pkg.sv =====
// ----------------------------------------------------------------------------
// scss_pkg
// Sizes, codes and types shared by the symbol sync correlator.
// ----------------------------------------------------------------------------
package scss_pkg;
  localparam int WINDOW   = 1024;
  localparam int WIN_AW   = $clog2(WINDOW);
  localparam int FILL_W   = $clog2(WINDOW + 1);
  localparam int SAMPLE_W = 16;
  localparam int REF_AW   = 10;
  localparam int EN_W     = 41;
  localparam int ACC_W    = 42;
  localparam int MAG_W    = 41;
  localparam int MA_W     = 49;
  localparam int MB_W     = 41;
  localparam int PROD_W   = MA_W + MB_W;
  localparam int MCNT_W   = $clog2(MB_W);
  localparam int CFG_W    = 41;
  localparam int CFG_AW   = 2;
  localparam int THR_W    = 8;
  localparam int HIT_W    = 8;

  localparam logic [EN_W-1:0]  REF_ENERGY_RST = EN_W'(8295674);
  localparam logic [THR_W-1:0] THR_RST        = THR_W'(154);
  localparam logic [HIT_W-1:0] HIT_LIMIT_RST  = HIT_W'(8);
  localparam logic [HIT_W-1:0] HIT_MAX        = '1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  typedef enum logic [CFG_AW-1:0] {
    CFG_REF_ENERGY = 2'd0,
    CFG_THR        = 2'd1,
    CFG_HIT_LIMIT  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENERGY,
    S_CORR,
    S_DRAIN,
    S_SQ_WAIT,
    S_RHS_GO,
    S_RHS_WAIT,
    S_FIN
  } state_e;
endpackage

// ===== rtl/core/scss_stream_if.sv =====
// ----------------------------------------------------------------------------
// scss stream interfaces
// Input request channel and result channel with valid/ready.
// ----------------------------------------------------------------------------
interface scss_in_if;
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [9:0]           ref_index;
  logic signed [15:0]   value;
  modport source (output valid, opcode, ref_index, value, input ready);
  modport sink   (input valid, opcode, ref_index, value, output ready);
endinterface

interface scss_out_if;
  logic valid;
  logic ready;
  logic symbol_found;
  logic hit;
  modport source (output valid, symbol_found, hit, input ready);
  modport sink   (input valid, symbol_found, hit, output ready);
endinterface

// ===== rtl/core/sliding_correlation_symbol_sync.sv =====
// ----------------------------------------------------------------------------
// sliding_correlation_symbol_sync
// Sliding normalized cross-correlation preamble detector.
// ----------------------------------------------------------------------------
// Input channel in_s: opcode 1 writes value into reference word ref_index
// (no result); opcode 0 pushes a signal sample and yields one
// result on out_m (symbol_found, hit). Config writes via cfg_we_i/cfg_idx_i/
// cfg_data_i, only while idle.
// The window is a ring of 1024 sample cells. A sample shifts in at the
// newest end; for correlation the ring rotates once around, the oldest
// cell feeding one MAC against the reference memory.
// A sample while the window fills gives its result after the energy
// update; with a full window the ring rotation, the MAC pipe and the
// bit-serial multiplier for both sides of the compare come first.
// One request is in work at a time; in_s.ready is high only when idle.
// Reset clears the fill count, energy, hit count and registers to their
// defaults; window and reference contents are not cleared (load the
// reference first). A stalled receiver holds the block in its final state
// until the pending result is taken.
// ----------------------------------------------------------------------------
`include "sliding_correlation_symbol_sync_macros.svh"

module sliding_correlation_symbol_sync (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  scss_in_if.sink                        in_s,
  scss_out_if.source                     out_m,
  input  logic                           cfg_we_i,
  input  logic [scss_pkg::CFG_AW-1:0]    cfg_idx_i,
  input  logic [scss_pkg::CFG_W-1:0]     cfg_data_i
);
  import scss_pkg::*;

  state_e state_q, state_d;

  logic [EN_W-1:0]   ref_e_q;
  logic [THR_W-1:0]  thr_q;
  logic [HIT_W-1:0]  limit_q;

  logic [FILL_W-1:0] fill_q;
  logic [EN_W-1:0]   energy_q;
  logic [HIT_W-1:0]  hitcnt_q;
  logic [WIN_AW-1:0] cnt_q;

  logic signed [SAMPLE_W-1:0] new_q, old_q;
  logic signed [2*SAMPLE_W-1:0] new_sq, old_sq;
  logic                       had_old_q;

  logic signed [SAMPLE_W-1:0] ref_mem [WINDOW];
  logic signed [SAMPLE_W-1:0] rdata_q, tap_q;
  logic signed [2*SAMPLE_W-1:0] prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic                       p1_q, p2_q;

  logic signed [SAMPLE_W-1:0] cell_q [WINDOW];
  logic signed [SAMPLE_W-1:0] ring_in;
  logic                       ring_en, issue;

  logic [PROD_W-1:0] lhs_q;
  logic              mul_start, mul_done;
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [MAG_W-1:0]  mag;

  logic out_valid_q, found_q, hit_q;
  logic smp_acc, load_acc, fin_fire;
  logic hit_w, found_w;
  logic [HIT_W-1:0] hc_inc;

  assign in_s.ready = (state_q == S_IDLE);
  assign smp_acc    = in_s.valid && in_s.ready && (in_s.opcode == OP_SAMPLE);
  assign load_acc   = in_s.valid && in_s.ready && (in_s.opcode == OP_LOAD);
  assign issue      = (state_q == S_CORR);
  assign ring_en    = smp_acc || issue;
  assign ring_in    = smp_acc ? in_s.value : cell_q[0];

  // ring of sample cells, oldest at index 0
  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    scss_cell u_cell (
      .clk_i (clk_i),
      .en_i  (ring_en),
      .d_i   ((k == WINDOW - 1) ? ring_in : cell_q[(k + 1) % WINDOW]),
      .q_o   (cell_q[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      ref_mem[in_s.ref_index] <= in_s.value;
    end
    rdata_q <= ref_mem[cnt_q];
  end

  // full-width squares of the entering and leaving samples
  assign new_sq = new_q * new_q;
  assign old_sq = old_q * old_q;

  assign mag   = acc_q[ACC_W-1] ? MAG_W'(-acc_q) : MAG_W'(acc_q);
  assign mul_start = (state_q == S_DRAIN && !p1_q && !p2_q) || (state_q == S_RHS_GO);
  assign mul_a = (state_q == S_RHS_GO) ? MA_W'(MA_W'(thr_q) * MA_W'(ref_e_q))
                                       : MA_W'(mag);
  assign mul_b = (state_q == S_RHS_GO) ? MB_W'(energy_q) : MB_W'(mag);

  scss_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  assign hit_w   = (lhs_q > mul_p);
  assign hc_inc  = (hit_w && hitcnt_q != HIT_MAX) ? hitcnt_q + HIT_W'(1) : hitcnt_q;
  assign found_w = (hc_inc >= limit_q);
  assign fin_fire = (state_q == S_FIN) && (!out_valid_q || out_m.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (smp_acc) state_d = S_ENERGY;
      S_ENERGY:   state_d = (fill_q == FILL_W'(WINDOW)) ? S_CORR : S_FIN;
      S_CORR:     if (cnt_q == WIN_AW'(WINDOW - 1)) state_d = S_DRAIN;
      S_DRAIN:    if (!p1_q && !p2_q) state_d = S_SQ_WAIT;
      S_SQ_WAIT:  if (mul_done) state_d = S_RHS_GO;
      S_RHS_GO:   state_d = S_RHS_WAIT;
      S_RHS_WAIT: if (mul_done) state_d = S_FIN;
      S_FIN:      if (fin_fire) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ref_e_q     <= REF_ENERGY_RST;
      thr_q       <= THR_RST;
      limit_q     <= HIT_LIMIT_RST;
      fill_q      <= '0;
      energy_q    <= '0;
      hitcnt_q    <= '0;
      cnt_q       <= '0;
      p1_q        <= 1'b0;
      p2_q        <= 1'b0;
      had_old_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_REF_ENERGY: ref_e_q <= EN_W'(cfg_data_i);
          CFG_THR:        thr_q   <= THR_W'(cfg_data_i);
          CFG_HIT_LIMIT:  limit_q <= HIT_W'(cfg_data_i);
          default:        ;
        endcase
      end
      if (smp_acc) begin
        had_old_q <= (fill_q == FILL_W'(WINDOW));
        if (fill_q != FILL_W'(WINDOW)) fill_q <= fill_q + FILL_W'(1);
        cnt_q <= '0;
      end
      if (state_q == S_ENERGY) begin
        energy_q <= energy_q + EN_W'(unsigned'(new_sq))
                    - (had_old_q ? EN_W'(unsigned'(old_sq)) : EN_W'(0));
      end
      if (issue) cnt_q <= cnt_q + WIN_AW'(1);
      p1_q <= issue;
      p2_q <= p1_q;
      if (fin_fire) begin
        out_valid_q <= 1'b1;
        if (fill_q == FILL_W'(WINDOW)) begin
          hitcnt_q <= found_w ? '0 : hc_inc;
        end
      end else if (out_m.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      new_q <= in_s.value;
      old_q <= cell_q[0];
      acc_q <= '0;
    end else if (p2_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    tap_q  <= cell_q[0];
    prod_q <= tap_q * rdata_q;
    if (state_q == S_SQ_WAIT && mul_done) begin
      lhs_q <= mul_p << 8;
    end
    if (fin_fire) begin
      found_q <= (fill_q == FILL_W'(WINDOW)) && found_w;
      hit_q   <= (fill_q == FILL_W'(WINDOW)) && hit_w;
    end
  end

  assign out_m.valid        = out_valid_q;
  assign out_m.symbol_found = found_q;
  assign out_m.hit          = hit_q;

  `SCSS_ASSERT_IMP(a_corr_full, clk_i, rst_ni, state_q == S_CORR, fill_q == FILL_W'(WINDOW))
  `SCSS_ASSERT_NXT(a_smp_energy, clk_i, rst_ni, smp_acc, state_q == S_ENERGY)
  `SCSS_ASSERT_IMP(a_mul_done, clk_i, rst_ni, mul_done, state_q == S_SQ_WAIT || state_q == S_RHS_WAIT)
endmodule

// ===== rtl/core/scss_cell.sv =====
// ----------------------------------------------------------------------------
// scss_cell
// One window sample; loads from its neighbor when the ring moves.
// ----------------------------------------------------------------------------
module scss_cell (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [scss_pkg::SAMPLE_W-1:0]  d_i,
  output logic signed [scss_pkg::SAMPLE_W-1:0]  q_o
);
  import scss_pkg::*;

  logic signed [SAMPLE_W-1:0] smp_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      smp_q <= d_i;
    end
  end

  assign q_o = smp_q;
endmodule

// ===== rtl/core/scss_mul.sv =====
// ----------------------------------------------------------------------------
// scss_mul
// Unsigned shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module scss_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [scss_pkg::MA_W-1:0]     a_i,
  input  logic [scss_pkg::MB_W-1:0]     b_i,
  output logic                          done_o,
  output logic [scss_pkg::PROD_W-1:0]   p_o
);
  import scss_pkg::*;

  logic              busy_q, done_q;
  logic [MCNT_W-1:0] cnt_q;
  logic [PROD_W-1:0] acc_q, a_q;
  logic [MB_W-1:0]   b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + MCNT_W'(1);
        if (cnt_q == MCNT_W'(MB_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= PROD_W'(a_i);
      b_q   <= b_i;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the sliding correlation symbol sync against a cycle-free predictor.
// A reference with a 32-word period is loaded, the window is filled with the
// same periodic signal plus noise, and hits/symbol decisions are compared
// over several threshold, energy and limit settings.
// ----------------------------------------------------------------------------
module tb;
  import scss_pkg::*;

  localparam int  PERIOD    = 32;
  localparam int  SETTLE    = 16;
  localparam int  TAIL      = 1200;
  localparam longint LIMIT  = 2000000;

  typedef struct {
    logic found;
    logic hit;
  } sync_result_t;

  typedef struct {
    logic        op;
    int          idx;
    int          val;
    bit          typed;
    logic        found;
    logic        hit;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we;
  logic [CFG_AW-1:0] cfg_idx;
  logic [CFG_W-1:0]  cfg_data;

  scss_in_if  in_if ();
  scss_out_if out_if ();

  sliding_correlation_symbol_sync u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_s       (in_if),
    .out_m      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  int              win_mem [WINDOW];
  int              ref_mem [WINDOW];
  int              fill_cnt;
  int              head;
  longint          win_energy;
  int              hit_cnt;
  logic [EN_W-1:0] ref_energy_q;
  logic [7:0]      thr_q;
  logic [7:0]      hit_limit_q;

  sync_result_t    pending [$];
  int              errors;
  longint          cycles;
  int              sample_no;
  int              base [PERIOD];
  bit              no_idle;
  bit              long_hold;
  int              stall_cnt;

  task automatic report(string what, logic expv, logic gotv);
    $display("mismatch %s: expected %0b got %0b (cycle %0d)", what, expv, gotv, cycles);
    errors++;
  endtask

  function automatic sync_result_t predict_sync(logic op, int idx, logic [15:0] val);
    sync_result_t r;
    int s;
    longint corr, mag;
    logic [127:0] lhs, rhs;
    int pos;
    r.found = 1'b0;
    r.hit   = 1'b0;
    if (op == OP_LOAD) begin
      ref_mem[idx] = $signed(val);
      return r;
    end
    s = $signed(val);
    if (fill_cnt >= WINDOW) win_energy -= longint'(win_mem[head]) * win_mem[head];
    else fill_cnt++;
    win_energy += longint'(s) * s;
    win_mem[head] = s;
    head = (head + 1) % WINDOW;
    if (fill_cnt < WINDOW) return r;
    corr = 0;
    pos  = head;
    for (int i = 0; i < WINDOW; i++) begin
      corr += longint'(win_mem[pos]) * ref_mem[i];
      pos = (pos + 1) % WINDOW;
    end
    mag = corr < 0 ? -corr : corr;
    lhs = (128'(mag) * 128'(mag)) << 8;
    rhs = 128'(thr_q) * 128'(ref_energy_q) * 128'(win_energy);
    r.hit = lhs > rhs;
    if (r.hit && hit_cnt < 255) hit_cnt++;
    r.found = hit_cnt >= hit_limit_q;
    if (r.found) hit_cnt = 0;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // drive one request, wait for acceptance, then predict
  task automatic send(logic op, int idx, int val, bit typed = 0,
                      logic tf = 1'b0, logic th = 1'b0);
    sync_result_t r;
    int gap;
    in_if.valid     <= 1'b1;
    in_if.opcode    <= op;
    in_if.ref_index <= idx[9:0];
    in_if.value     <= val[15:0];
    do @(posedge clk_i); while (!in_if.ready);
    r = predict_sync(op, idx, val[15:0]);
    if (op == OP_SAMPLE) begin
      sample_no++;
      if (typed) begin
        r.found = tf;
        r.hit   = th;
      end
      pending.push_back(r);
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    wait (pending.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    case (idx)
      CFG_REF_ENERGY: ref_energy_q = data[EN_W-1:0];
      CFG_THR:        thr_q        = data[7:0];
      default:        hit_limit_q  = data[7:0];
    endcase
  endtask

  function automatic int next_sample(int noise_pct);
    if ($urandom_range(0, 99) < noise_pct) return int'($urandom);
    return base[sample_no % PERIOD] + $urandom_range(0, 400) - 200;
  endfunction

  function automatic logic [CFG_W-1:0] ref_sum_sq();
    longint acc;
    acc = 0;
    for (int i = 0; i < WINDOW; i++) acc += longint'(ref_mem[i]) * ref_mem[i];
    return CFG_W'(acc);
  endfunction

  task automatic run_samples(int n, int noise_pct);
    for (int i = 0; i < n; i++) send(OP_SAMPLE, 0, next_sample(noise_pct));
  endtask

  // result side: random backpressure plus an occasional long hold
  initial begin
    out_if.ready = 1'b0;
    stall_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        long_hold = 1'b0;
        stall_cnt = 2000;
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_if.ready <= 1'b0;
      end else if (no_idle || $urandom_range(0, 99) < 85) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b0;
        stall_cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                  : $urandom_range(0, 3);
      end
    end
  end

  always @(posedge clk_i) begin
    sync_result_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending.size() == 0) begin
        report("unexpected result", 1'b0, 1'b1);
      end else begin
        e = pending.pop_front();
        if (out_if.symbol_found !== e.found) report("symbol_found", e.found,
                                                      out_if.symbol_found);
        if (out_if.hit !== e.hit) report("hit", e.hit, out_if.hit);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  dir_row_t dir_tab [] = '{
    '{OP_LOAD,   0,    -32768, 0, 1'b0, 1'b0},
    '{OP_LOAD,   1023, 32767,  0, 1'b0, 1'b0},
    '{OP_LOAD,   512,  0,      0, 1'b0, 1'b0},
    '{OP_LOAD,   1,    -1,     0, 1'b0, 1'b0},
    '{OP_LOAD,   682,  16'h5555, 0, 1'b0, 1'b0},
    '{OP_LOAD,   341,  16'hAAAA, 0, 1'b0, 1'b0},
    '{OP_SAMPLE, 0,    32767,  1, 1'b0, 1'b0},
    '{OP_SAMPLE, 0,    -32768, 1, 1'b0, 1'b0},
    '{OP_SAMPLE, 0,    0,      1, 1'b0, 1'b0},
    '{OP_SAMPLE, 0,    -1,     1, 1'b0, 1'b0},
    '{OP_SAMPLE, 0,    1,      1, 1'b0, 1'b0},
    '{OP_SAMPLE, 1023, 16'h5555, 1, 1'b0, 1'b0},
    '{OP_SAMPLE, 512,  16'hAAAA, 1, 1'b0, 1'b0},
    '{OP_SAMPLE, 0,    -32768, 1, 1'b0, 1'b0}
  };

  initial begin
    errors = 0;
    cycles = 0;
    sample_no = 0;
    fill_cnt = 0;
    head = 0;
    win_energy = 0;
    hit_cnt = 0;
    no_idle = 0;
    long_hold = 0;
    ref_energy_q = REF_ENERGY_RST;
    thr_q = THR_RST;
    hit_limit_q = HIT_LIMIT_RST;
    foreach (win_mem[i]) win_mem[i] = 0;
    foreach (ref_mem[i]) ref_mem[i] = 0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_SAMPLE;
    in_if.ref_index = '0;
    in_if.value = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i])
      send(dir_tab[i].op, dir_tab[i].idx, dir_tab[i].val, dir_tab[i].typed,
           dir_tab[i].found, dir_tab[i].hit);

    // periodic reference, full table written before the window fills
    foreach (base[i]) base[i] = $urandom_range(0, 40000) - 20000;
    for (int i = 0; i < WINDOW; i++) send(OP_LOAD, i, base[i % PERIOD]);

    // fill the window; hold the result side off once so the input stalls
    long_hold = 1'b1;
    run_samples(200, 5);
    no_idle = 1;
    run_samples(200, 5);
    no_idle = 0;
    run_samples(WINDOW - 1 - sample_no, 5);

    // full window at reset settings, only the energy matched to the reference
    drain();
    write_reg(CFG_REF_ENERGY, ref_sum_sq());
    run_samples(64, 8);

    drain();
    write_reg(CFG_HIT_LIMIT, 1);
    run_samples(40, 8);

    // zero threshold accumulates; then drop the limit below the count
    drain();
    write_reg(CFG_THR, 0);
    write_reg(CFG_HIT_LIMIT, 255);
    run_samples(10, 20);
    drain();
    write_reg(CFG_HIT_LIMIT, 2);
    run_samples(10, 20);

    drain();
    write_reg(CFG_THR, 255);
    write_reg(CFG_REF_ENERGY, {CFG_W{1'b1}});
    write_reg(CFG_HIT_LIMIT, 1);
    run_samples(16, 10);

    // zero reference energy; limit zero declares on every sample
    drain();
    write_reg(CFG_REF_ENERGY, 0);
    write_reg(CFG_THR, 200);
    write_reg(CFG_HIT_LIMIT, 0);
    run_samples(10, 10);

    // partial reload mixed with samples
    drain();
    write_reg(CFG_THR, 154);
    write_reg(CFG_HIT_LIMIT, 3);
    write_reg(CFG_REF_ENERGY, ref_sum_sq());
    for (int i = 0; i < 48; i++) begin
      if ($urandom_range(0, 3) == 0)
        send(OP_LOAD, $urandom_range(0, WINDOW - 1), $urandom);
      send(OP_SAMPLE, 0, next_sample(12));
    end

    drain();
    repeat (TAIL) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/scss_pkg.sv
rtl/core/scss_stream_if.sv
rtl/core/scss_cell.sv
rtl/core/scss_mul.sv
rtl/core/sliding_correlation_symbol_sync.sv
test/tb.sv
